FILE: sv/dsss_pkg.sv
`timescale 1ns / 1ps

package dsss_pkg;

  // store geometry
  localparam int unsigned Depth  = 64;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned SumW   = CntW + 1;

  // payload widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TotalW  = 7;

  // operation codes
  typedef enum logic [FuncW-1:0] {
    OpPush  = 2'd0,
    OpPop   = 2'd1,
    OpClear = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // item accepted this cycle
    logic capture;  // store read data is valid
  } dsss_cmd_t;

endpackage

FILE: sv/dsss_req_if.sv
`timescale 1ns / 1ps

interface dsss_req_if;
  import dsss_pkg::*;

  logic               valid;
  logic               ready;
  logic [FuncW-1:0]   func;
  logic               stack_sel;
  logic signed [KeyW-1:0] push_key;

  modport source (output valid, output func, output stack_sel, output push_key,
                  input ready);
  modport sink   (input valid, input func, input stack_sel, input push_key,
                  output ready);
endinterface

FILE: sv/dsss_rsp_if.sv
`timescale 1ns / 1ps

interface dsss_rsp_if;
  import dsss_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StatusW-1:0]     status;
  logic signed [KeyW-1:0] pop_key;
  logic [TotalW-1:0]      total_count;

  modport source (output valid, output status, output pop_key, output total_count,
                  input ready);
  modport sink   (input valid, input status, input pop_key, input total_count,
                  output ready);
endinterface

FILE: sv/dual_stack_shared_store_core.sv
`timescale 1ns / 1ps

// channel  dir  modport  payload
// req_i    in   sink     func, stack_sel, push_key
// rsp_o    out  source   status, pop_key, total_count
//
// one item at a time: accept, store read, result; the result then waits
// for rsp_o.ready before the next item is accepted
// the single registered read port of the key store sets the store read step
// reset clears both stack pointers; the key store itself is not cleared
// req_i.ready stays low from acceptance until the result is taken

module dual_stack_shared_store_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsss_req_if.sink   req_i,
  dsss_rsp_if.source rsp_o
);
  import dsss_pkg::*;

  dsss_cmd_t cmd;

  dsss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  dsss_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (req_i.func),
    .stack_sel_i   (req_i.stack_sel),
    .push_key_i    (req_i.push_key),
    .status_o      (rsp_o.status),
    .pop_key_o     (rsp_o.pop_key),
    .total_count_o (rsp_o.total_count)
  );

  // no new item while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("item accepted while a result is pending");

  // an accepted item blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !req_i.ready)
    else $error("input still open after accept");

  // a failed operation returns a zero key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != StOk) |-> (rsp_o.pop_key == '0))
    else $error("nonzero key on failed operation");

  // store read data is captured in the cycle after the accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.capture)
    else $error("capture does not follow accept");

endmodule

FILE: sv/dsss_ram.sv
`timescale 1ns / 1ps

module dsss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/dsss_ctrl.sv
`timescale 1ns / 1ps

module dsss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output dsss_pkg::dsss_cmd_t cmd_o
);
  import dsss_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StOut
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   valid_q;

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (req_valid_i) begin
            state_q <= StRead;
            ready_q <= 1'b0;
          end
        end
        StRead: begin
          state_q <= StOut;
          valid_q <= 1'b1;
        end
        StOut: begin
          if (rsp_ready_i) begin
            state_q <= StIdle;
            valid_q <= 1'b0;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
          ready_q <= 1'b1;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign req_ready_o   = ready_q;
  assign rsp_valid_o   = valid_q;
  assign cmd_o.load    = req_valid_i & ready_q;
  assign cmd_o.capture = (state_q == StRead);

endmodule

FILE: sv/dsss_dp.sv
`timescale 1ns / 1ps

module dsss_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dsss_pkg::dsss_cmd_t                  cmd_i,
  input  logic [dsss_pkg::FuncW-1:0]           func_i,
  input  logic                                 stack_sel_i,
  input  logic signed [dsss_pkg::KeyW-1:0]     push_key_i,
  output logic [dsss_pkg::StatusW-1:0]         status_o,
  output logic signed [dsss_pkg::KeyW-1:0]     pop_key_o,
  output logic [dsss_pkg::TotalW-1:0]          total_count_o
);
  import dsss_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [CntW-1:0]    lower_q, lower_d;
  logic [CntW-1:0]    upper_q, upper_d;
  logic [SumW-1:0]    used;
  logic               full;
  logic [CntW-1:0]    lower_dec, upper_dec;
  logic               we, re, pop_ok;
  logic [AddrW-1:0]   waddr, raddr;
  logic [StatusW-1:0] status_d;
  logic [SumW-1:0]    sum_d;
  logic [StatusW-1:0] status_q;
  logic               pop_ok_q;
  logic [TotalW-1:0]  total_q;
  logic [KeyW-1:0]    pop_key_q;
  logic [KeyW-1:0]    rdata;

  assign used      = {1'b0, lower_q} + {1'b0, upper_q};
  assign full      = (used >= SumW'(Depth));
  assign lower_dec = lower_q - CntW'(1);
  assign upper_dec = upper_q - CntW'(1);

  // next counts, store access and status for the current item
  always_comb begin
    lower_d  = lower_q;
    upper_d  = upper_q;
    we       = 1'b0;
    re       = 1'b0;
    pop_ok   = 1'b0;
    waddr    = lower_q[AddrW-1:0];
    raddr    = lower_dec[AddrW-1:0];
    status_d = StOk;
    unique case (func_i)
      OpPush: begin
        if (full) begin
          status_d = StFull;
        end else if (!stack_sel_i) begin
          we      = 1'b1;
          waddr   = lower_q[AddrW-1:0];
          lower_d = lower_q + CntW'(1);
        end else begin
          we      = 1'b1;
          waddr   = LastAddr - upper_q[AddrW-1:0];
          upper_d = upper_q + CntW'(1);
        end
      end
      OpPop: begin
        if (!stack_sel_i) begin
          if (lower_q == '0) begin
            status_d = StEmpty;
          end else begin
            re      = 1'b1;
            pop_ok  = 1'b1;
            raddr   = lower_dec[AddrW-1:0];
            lower_d = lower_dec;
          end
        end else begin
          if (upper_q == '0) begin
            status_d = StEmpty;
          end else begin
            re      = 1'b1;
            pop_ok  = 1'b1;
            raddr   = LastAddr - upper_dec[AddrW-1:0];
            upper_d = upper_dec;
          end
        end
      end
      OpClear: begin
        lower_d = '0;
        upper_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign sum_d = {1'b0, lower_d} + {1'b0, upper_d};

  // stack pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
    end else if (cmd_i.load) begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok;
      total_q  <= TotalW'(sum_d);
    end
    if (cmd_i.capture) begin
      pop_key_q <= pop_ok_q ? rdata : '0;
    end
  end

  dsss_ram #(
    .Width (KeyW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load & we),
    .waddr_i (waddr),
    .wdata_i (push_key_i),
    .re_i    (cmd_i.load & re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign status_o      = status_q;
  assign pop_key_o     = pop_key_q;
  assign total_count_o = total_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import dsss_pkg::*;

  // stack selection and the unused operation code
  localparam logic             LowerStack = 1'b0;
  localparam logic             UpperStack = 1'b1;
  localparam logic [FuncW-1:0] OpSpare    = 2'd3;

  // cycles without any handshake before the run is abandoned
  localparam int unsigned WatchdogLimit = 2000;
  // cycles to let pass once every expected result is in
  localparam int unsigned SettleCycles  = 10;

  typedef struct {
    status_e                status;
    logic signed [KeyW-1:0] key;
    logic [TotalW-1:0]      total;
  } stack_rsp_t;

  logic clk;
  logic rst_n;

  dsss_req_if req_if ();
  dsss_rsp_if rsp_if ();

  dual_stack_shared_store_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow of the shared store and both stack depths
  logic [KeyW-1:0] key_mem [Depth];
  int unsigned     lower_cnt;
  int unsigned     upper_cnt;

  stack_rsp_t  pending_rsp_q [$];
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // apply one operation to the shadow stacks and queue its result
  function automatic void apply_stack_op(input logic [FuncW-1:0] func, input logic sel,
                                         input logic [KeyW-1:0] key);
    stack_rsp_t exp_rsp;
    exp_rsp.status = StOk;
    exp_rsp.key    = '0;
    case (func)
      OpPush: begin
        if (lower_cnt + upper_cnt >= Depth) begin
          exp_rsp.status = StFull;
        end else if (sel == LowerStack) begin
          key_mem[lower_cnt] = key;
          lower_cnt++;
        end else begin
          key_mem[Depth - 1 - upper_cnt] = key;
          upper_cnt++;
        end
      end
      OpPop: begin
        if (sel == LowerStack) begin
          if (lower_cnt == 0) begin
            exp_rsp.status = StEmpty;
          end else begin
            lower_cnt--;
            exp_rsp.key = key_mem[lower_cnt];
          end
        end else begin
          if (upper_cnt == 0) begin
            exp_rsp.status = StEmpty;
          end else begin
            upper_cnt--;
            exp_rsp.key = key_mem[Depth - 1 - upper_cnt];
          end
        end
      end
      OpClear: begin
        lower_cnt = 0;
        upper_cnt = 0;
      end
      default: begin
      end
    endcase
    exp_rsp.total = TotalW'(lower_cnt + upper_cnt);
    pending_rsp_q.push_back(exp_rsp);
  endfunction

  // compare one returned result with the oldest expectation
  task automatic check_rsp();
    stack_rsp_t exp_rsp;
    if (pending_rsp_q.size() == 0) begin
      $display("%0t: unexpected result status %0d pop_key %h total %0d", $time,
               rsp_if.status, rsp_if.pop_key, rsp_if.total_count);
      mismatch_cnt++;
    end else begin
      exp_rsp = pending_rsp_q.pop_front();
      if (rsp_if.status !== exp_rsp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                 rsp_if.status);
        mismatch_cnt++;
      end
      if (rsp_if.pop_key !== exp_rsp.key) begin
        $display("%0t: pop_key expected %h actual %h", $time, exp_rsp.key, rsp_if.pop_key);
        mismatch_cnt++;
      end
      if (rsp_if.total_count !== exp_rsp.total) begin
        $display("%0t: total_count expected %0d actual %0d", $time, exp_rsp.total,
                 rsp_if.total_count);
        mismatch_cnt++;
      end
    end
  endtask

  // result sink: random stalls, checking and the watchdog
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        check_rsp();
      end
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // drive one item and wait for it to be taken
  task automatic send_item(input logic [FuncW-1:0] func, input logic sel,
                           input logic [KeyW-1:0] key);
    while ($urandom_range(99) < src_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= func;
    req_if.stack_sel <= sel;
    req_if.push_key  <= key;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_stack_op(func, sel, key);
  endtask

  // sender quiet until every expected result has come back
  task automatic hold_off();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
  endtask

  // mostly random keys, now and then an extreme
  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // empty pops, extreme keys, both sides, clear and the unused code
  task automatic test_directed();
    send_item(OpPop,   LowerStack, 32'h1234_5678);
    send_item(OpPop,   UpperStack, 32'h0);
    send_item(OpSpare, LowerStack, 32'h0);
    send_item(OpPush,  LowerStack, 32'h7fff_ffff);
    send_item(OpPush,  UpperStack, 32'h8000_0000);
    send_item(OpPush,  LowerStack, 32'h0000_0000);
    send_item(OpPush,  UpperStack, 32'hffff_ffff);
    send_item(OpSpare, UpperStack, 32'hdead_beef);
    send_item(OpPop,   UpperStack, 32'h0);
    send_item(OpPop,   LowerStack, 32'h0);
    send_item(OpPop,   LowerStack, 32'h0);
    send_item(OpPop,   LowerStack, 32'h0);
    send_item(OpPop,   UpperStack, 32'h0);
    send_item(OpPop,   UpperStack, 32'h0);
    send_item(OpPush,  LowerStack, 32'haaaa_aaaa);
    send_item(OpPush,  UpperStack, 32'h5555_5555);
    send_item(OpClear, UpperStack, 32'hffff_ffff);
    send_item(OpPop,   LowerStack, 32'h0);
    send_item(OpPop,   UpperStack, 32'h0);
    send_item(OpPush,  UpperStack, 32'h0000_0001);
    send_item(OpPop,   UpperStack, 32'h0);
    send_item(OpClear, LowerStack, 32'h0);
  endtask

  // fill the store until the stacks meet, push into it full, then drain
  task automatic test_fill_drain(input int unsigned upper_pct);
    while (lower_cnt + upper_cnt < Depth) begin
      send_item(OpPush, $urandom_range(99) < upper_pct, pick_key());
    end
    send_item(OpPush,  LowerStack, pick_key());
    send_item(OpPush,  UpperStack, pick_key());
    send_item(OpSpare, 1'($urandom_range(1)), $urandom);
    while (lower_cnt + upper_cnt > 0) begin
      if (lower_cnt == 0) begin
        send_item(OpPop, UpperStack, $urandom);
      end else if (upper_cnt == 0) begin
        send_item(OpPop, LowerStack, $urandom);
      end else begin
        send_item(OpPop, 1'($urandom_range(1)), $urandom);
      end
    end
    send_item(OpPop, LowerStack, $urandom);
    send_item(OpPop, UpperStack, $urandom);
  endtask

  // bursts that lean toward push or pop and toward one side
  task automatic test_random_ops(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned push_pct;
    int unsigned upper_pct;
    int unsigned roll;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(40, 8);
      case ($urandom_range(3))
        0:       push_pct = 20;
        1:       push_pct = 50;
        2:       push_pct = 80;
        default: push_pct = 95;
      endcase
      case ($urandom_range(2))
        0:       upper_pct = 10;
        1:       upper_pct = 50;
        default: upper_pct = 90;
      endcase
      repeat (burst_len) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          send_item(OpClear, 1'($urandom_range(1)), $urandom);
        end else if (roll < 4) begin
          send_item(OpSpare, 1'($urandom_range(1)), $urandom);
        end else if ($urandom_range(99) < push_pct) begin
          send_item(OpPush, $urandom_range(99) < upper_pct, pick_key());
        end else begin
          send_item(OpPop, $urandom_range(99) < upper_pct, $urandom);
        end
        sent++;
      end
    end
  endtask

  // one idling setting: fill and drain, then random traffic
  task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                           input int unsigned upper_pct);
    set_idling(gap_pct, stall_pct);
    test_fill_drain(upper_pct);
    hold_off();
    test_random_ops(300);
    hold_off();
  endtask

  initial begin
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.func      <= OpPush;
    req_if.stack_sel <= LowerStack;
    req_if.push_key  <= '0;
    lower_cnt        = 0;
    upper_cnt        = 0;
    mismatch_cnt     = 0;
    set_idling(0, 0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    hold_off();
    run_phase(0, 0, 50);
    run_phase(63, 0, 0);
    run_phase(0, 63, 100);
    run_phase(32, 32, 30);

    hold_off();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
